### src/i8gd_pkg.sv
// Package for the int8 GEMM tile engine with row/column dequantization.
// Holds shared widths, default parameters and the element tag type.
// No dependencies.
package i8gd_pkg;

  localparam int TILE_ROWS_DEF = 8;
  localparam int TILE_COLS_DEF = 8;
  localparam int ACC_BITS_DEF  = 32;

  localparam int IDX_W   = 3;   // row, column and lane index width
  localparam int SCALE_W = 24;  // signed Q4.20 scale
  localparam int BYTE_W  = 8;
  localparam int HALF_W  = 16;
  localparam int LANES   = 8;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_ACC  = 1'b1;

  // Position of one element travelling through the dequant pipeline
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } tag_t;

endpackage

### src/int8_gemm_tile_dequant.sv
// Top level of the int8 GEMM output tile engine with per-row and
// per-column dequantization. Depends on i8gd_pkg, i8gd_cell, i8gd_dequant.
//
// Usage:
// - Command channel: a transfer happens at a rising edge with start_i high
//   and busy_o low. req_type_i low loads the row and column scale of
//   lane_i; high adds the outer product of a_column_i and b_row_i into the
//   accumulator tile, one accumulate per cycle while busy_o is low.
// - An accumulate with last_step_i high ends the tile: after its own add,
//   the accumulator cells shift toward the head of the chain, one element
//   per cycle in row-major order, and zeros enter at the tail, so the tile
//   is clear when the drain ends. busy_o stays high while the tile
//   drains.
// - Each drained element passes a nine-stage dequant pipeline (two
//   multiplier stages, leading-one search, rounding to binary16). Results
//   come out one per cycle, marked by out_valid_o, with last_of_tile_o on
//   the final one.
// - Only the drain raises busy_o; it sets the cost of a tile end. The next
//   tile may start while results still flow.
// - The receiver cannot stall; each result is shown for one cycle only.
// - Reset clears the accumulators and all control state. Scales must be
//   loaded before a tile ends.
module int8_gemm_tile_dequant #(
  parameter int TILE_ROWS = i8gd_pkg::TILE_ROWS_DEF,
  parameter int TILE_COLS = i8gd_pkg::TILE_COLS_DEF,
  parameter int ACC_BITS  = i8gd_pkg::ACC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          req_type_i,
  input  logic [i8gd_pkg::IDX_W-1:0]    lane_i,
  input  logic [i8gd_pkg::SCALE_W-1:0]  row_scale_i,
  input  logic [i8gd_pkg::SCALE_W-1:0]  col_scale_i,
  input  logic [63:0]                   a_column_i,
  input  logic [63:0]                   b_row_i,
  input  logic                          last_step_i,
  output logic                          out_valid_o,
  output logic [i8gd_pkg::IDX_W-1:0]    out_row_o,
  output logic [i8gd_pkg::IDX_W-1:0]    out_col_o,
  output logic [i8gd_pkg::HALF_W-1:0]   half_value_o,
  output logic                          last_of_tile_o
);
  import i8gd_pkg::*;

  localparam int NCELL = TILE_ROWS * TILE_COLS;

  logic take, acc_en, drain_end;
  logic drain_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic [SCALE_W-1:0] row_scales_q [LANES];
  logic [SCALE_W-1:0] col_scales_q [LANES];
  logic [ACC_BITS-1:0] chain [NCELL+1];
  tag_t head_tag, out_tag;

  assign take      = start_i & ~drain_q;
  assign acc_en    = take & (req_type_i == REQ_ACC);
  assign drain_end = (row_q == IDX_W'(TILE_ROWS - 1)) && (col_q == IDX_W'(TILE_COLS - 1));

  // Tail of the chain feeds zeros, which clears the tile while it drains.
  assign chain[NCELL] = '0;

  for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
    for (genvar c = 0; c < TILE_COLS; c++) begin : g_col
      i8gd_cell #(.ACC_BITS(ACC_BITS)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .acc_en_i   (acc_en),
        .shift_en_i (drain_q),
        .a_i        (a_column_i[BYTE_W*r +: BYTE_W]),
        .b_i        (b_row_i[BYTE_W*c +: BYTE_W]),
        .shift_in_i (chain[r*TILE_COLS + c + 1]),
        .acc_o      (chain[r*TILE_COLS + c])
      );
    end
  end

  // Scale store: written by load transfers only.
  always_ff @(posedge clk_i) begin
    if (take && (req_type_i == REQ_LOAD)) begin
      row_scales_q[lane_i] <= row_scale_i;
      col_scales_q[lane_i] <= col_scale_i;
    end
  end

  // Drain sequencer: start after the last-step add, walk row-major.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
    end else if (drain_q) begin
      if (drain_end) begin
        drain_q <= 1'b0;
        row_q   <= '0;
        col_q   <= '0;
      end else if (col_q == IDX_W'(TILE_COLS - 1)) begin
        col_q <= '0;
        row_q <= row_q + IDX_W'(1);
      end else begin
        col_q <= col_q + IDX_W'(1);
      end
    end else if (acc_en && last_step_i) begin
      drain_q <= 1'b1;
    end
  end

  assign head_tag.row  = row_q;
  assign head_tag.col  = col_q;
  assign head_tag.last = drain_end;

  i8gd_dequant #(.ACC_BITS(ACC_BITS)) u_dequant (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (drain_q),
    .acc_i   (chain[0]),
    .rs_i    (row_scales_q[row_q]),
    .cs_i    (col_scales_q[col_q]),
    .tag_i   (head_tag),
    .valid_o (out_valid_o),
    .tag_o   (out_tag),
    .half_o  (half_value_o)
  );

  assign busy_o         = drain_q;
  assign out_row_o      = out_tag.row;
  assign out_col_o      = out_tag.col;
  assign last_of_tile_o = out_valid_o & out_tag.last;

endmodule

### src/i8gd_cell.sv
// One accumulator cell of the tile chain: multiply-accumulate of two int8
// values, or shift from the neighbor cell while the tile drains.
// Depends on i8gd_pkg.
module i8gd_cell #(
  parameter int ACC_BITS = i8gd_pkg::ACC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        acc_en_i,
  input  logic                        shift_en_i,
  input  logic [i8gd_pkg::BYTE_W-1:0] a_i,
  input  logic [i8gd_pkg::BYTE_W-1:0] b_i,
  input  logic [ACC_BITS-1:0]         shift_in_i,
  output logic [ACC_BITS-1:0]         acc_o
);
  import i8gd_pkg::*;

  logic [ACC_BITS-1:0] acc_q, acc_d;
  logic signed [2*BYTE_W-1:0] prod;

  assign prod = $signed(a_i) * $signed(b_i);

  always_comb begin
    acc_d = acc_q;
    if (shift_en_i) begin
      acc_d = shift_in_i;
    end else if (acc_en_i) begin
      acc_d = acc_q + ACC_BITS'(prod);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### src/i8gd_dequant.sv
// Dequant pipeline: accumulator times row scale times column scale, then
// rounding to binary16 (nearest even). Nine register stages.
// Depends on i8gd_pkg.
module i8gd_dequant #(
  parameter int ACC_BITS = i8gd_pkg::ACC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [ACC_BITS-1:0]          acc_i,
  input  logic [i8gd_pkg::SCALE_W-1:0] rs_i,
  input  logic [i8gd_pkg::SCALE_W-1:0] cs_i,
  input  i8gd_pkg::tag_t               tag_i,
  output logic                         valid_o,
  output i8gd_pkg::tag_t               tag_o,
  output logic [i8gd_pkg::HALF_W-1:0]  half_o
);
  import i8gd_pkg::*;

  localparam int NST = 9;
  localparam int AW  = 48;  // padded accumulator magnitude
  localparam int PW  = 48;  // 24x24 partial product
  localparam int XW  = 72;
  localparam int MW  = 96;
  localparam int NCH = MW / 16;

  logic [NST-1:0] v_q;
  tag_t           tag_q [NST];
  logic           neg_q [NST];

  // stage 1: magnitudes
  logic [AW-1:0]      am_q;
  logic [SCALE_W-1:0] rm_q, cm1_q;
  // stage 2: accumulator times row scale, two partial products
  logic [PW-1:0]      plo_q, phi_q;
  logic [SCALE_W-1:0] cm2_q;
  // stage 3: sum
  logic [XW-1:0]      x_q;
  logic [SCALE_W-1:0] cm3_q;
  // stage 4: times column scale, three partial products
  logic [PW-1:0]      q0_q, q1_q, q2_q;
  // stage 5: full product with 40 fractional bits
  logic [MW-1:0]      m5_q;
  // stage 6: per-chunk leading one
  logic [MW-1:0]      m6_q;
  logic [NCH-1:0]     nz_q;
  logic [3:0]         pos_q [NCH];
  // stage 7: leading-one position
  logic [MW-1:0]      m7_q;
  logic [6:0]         p7_q;
  logic               z7_q;
  // stage 8: shifted significand and rounding bits
  logic [10:0]        r8_q;
  logic               g8_q, st8_q, z8_q;
  logic [6:0]         p8_q;
  // stage 9: packed result
  logic [HALF_W-1:0]  half_q;

  logic               sa, sr, sc;
  logic [ACC_BITS-1:0] am_c;
  logic [SCALE_W-1:0] rm_c, cm_c;
  logic [NCH-1:0]     nz_c;
  logic [3:0]         pos_c [NCH];
  logic [6:0]         p_c, sh_c, s_c;
  logic [11:0]        rr_c;
  logic [16:0]        bits_c;
  logic [HALF_W-1:0]  half_c;

  assign sa   = acc_i[ACC_BITS-1];
  assign sr   = rs_i[SCALE_W-1];
  assign sc   = cs_i[SCALE_W-1];
  assign am_c = sa ? (~acc_i + ACC_BITS'(1)) : acc_i;
  assign rm_c = sr ? (~rs_i + SCALE_W'(1)) : rs_i;
  assign cm_c = sc ? (~cs_i + SCALE_W'(1)) : cs_i;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      nz_c[k]  = |m5_q[16*k +: 16];
      pos_c[k] = '0;
      for (int b = 0; b < 16; b++) begin
        if (m5_q[16*k + b]) pos_c[k] = 4'(b);
      end
    end
  end

  always_comb begin
    p_c = '0;
    for (int k = 0; k < NCH; k++) begin
      if (nz_q[k]) p_c = 7'(16 * k) + 7'(pos_q[k]);
    end
  end

  // Keep ten significand bits after the leading one, or align to the
  // subnormal grid when the value is small.
  assign s_c  = (p7_q > 7'd26) ? (p7_q - 7'd10) : 7'd16;
  assign sh_c = s_c - 7'd1;

  always_comb begin
    rr_c   = {1'b0, r8_q} + 12'(g8_q & (st8_q | r8_q[0]));
    bits_c = '0;
    if (p8_q <= 7'd26) begin
      bits_c = 17'(rr_c);
    end else if (p8_q - 7'd26 >= 7'd31) begin
      bits_c = 17'h07C00;
    end else begin
      bits_c = (17'(p8_q - 7'd26) << 10) + 17'(rr_c);
    end
    if (bits_c >= 17'h07C00) bits_c = 17'h07C00;
    half_c = {neg_q[7], 15'(bits_c)};
    if (z8_q) half_c = {neg_q[7], 15'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    neg_q[0] <= sa ^ sr ^ sc;
    for (int i = 1; i < NST; i++) begin
      tag_q[i] <= tag_q[i-1];
      neg_q[i] <= neg_q[i-1];
    end
    am_q  <= AW'(am_c);
    rm_q  <= rm_c;
    cm1_q <= cm_c;

    plo_q <= PW'(am_q[23:0]) * PW'(rm_q);
    phi_q <= PW'(am_q[47:24]) * PW'(rm_q);
    cm2_q <= cm1_q;

    x_q   <= (XW'(phi_q) << 24) + XW'(plo_q);
    cm3_q <= cm2_q;

    q0_q  <= PW'(x_q[23:0]) * PW'(cm3_q);
    q1_q  <= PW'(x_q[47:24]) * PW'(cm3_q);
    q2_q  <= PW'(x_q[71:48]) * PW'(cm3_q);

    m5_q  <= MW'(q0_q) + (MW'(q1_q) << 24) + (MW'(q2_q) << 48);

    m6_q  <= m5_q;
    nz_q  <= nz_c;
    for (int k = 0; k < NCH; k++) pos_q[k] <= pos_c[k];

    m7_q  <= m6_q;
    p7_q  <= p_c;
    z7_q  <= ~|nz_q;

    r8_q  <= 11'(m7_q >> s_c);
    g8_q  <= m7_q[sh_c];
    st8_q <= |(m7_q & ((MW'(1) << sh_c) - MW'(1)));
    z8_q  <= z7_q;
    p8_q  <= p7_q;

    half_q <= half_c;
  end

  assign valid_o = v_q[NST-1];
  assign tag_o   = tag_q[NST-1];
  assign half_o  = half_q;

endmodule

### src/i8gd_checker.sv
// Port-level checker for the int8 GEMM tile engine, bound to the top level.
// Depends on i8gd_pkg and int8_gemm_tile_dequant.
module i8gd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         req_type_i,
  input logic                         last_step_i,
  input logic                         out_valid_o,
  input logic                         last_of_tile_o
);
  import i8gd_pkg::*;

  // A drain starts only after a last-step accumulate transfer.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && (req_type_i == REQ_ACC) && last_step_i))
    else $error("busy rose without a last-step transfer");

  // Load transfers never start a drain.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (req_type_i == REQ_LOAD)) |=> !busy_o)
    else $error("scale load started a drain");

  // Results of one tile come out without gaps.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_tile_o) |=> out_valid_o)
    else $error("gap inside a tile's results");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_of_tile_o |-> out_valid_o)
    else $error("last_of_tile without a result");

endmodule

bind int8_gemm_tile_dequant i8gd_checker u_i8gd_checker (.*);
